/* hdl/lrd_pkg.sv */
// Shared types, codes and CRC helper for the log record deframer.
// No dependencies; used by log_record_deframer_crc32 and its testbench.
package lrd_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [31:0] MAGIC_RESET    = 32'h0000_0000;
  localparam logic [63:0] NULL_LEN_RESET = 64'h0000_0000_FFFF_FFFF;

  // register index, taken from paddr[3]
  localparam logic REG_MAGIC    = 1'b0;
  localparam logic REG_NULL_LEN = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_HEADER  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
  localparam logic [1:0] ST_CRC_ERR   = 2'd2;
  localparam logic [1:0] ST_TRUNC     = 2'd3;

  typedef enum logic [3:0] {
    PH_MAGIC,
    PH_SEQ,
    PH_OP,
    PH_UNIT,
    PH_COL,
    PH_ROW,
    PH_TXN,
    PH_COMMIT,
    PH_LEN,
    PH_PAYLOAD,
    PH_CRC,
    PH_DISCARD
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload;
    logic [63:0] seq;
    logic [7:0]  op;
    logic [31:0] unit;
    logic [31:0] col;
    logic [63:0] row;
    logic [63:0] txn;
    logic [63:0] commit;
    logic [63:0] len;
    logic [1:0]  status;
    logic        last;
  } result_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // index of the last byte of a header field
  function automatic logic [2:0] field_last_idx(input phase_t ph);
    logic [2:0] idx;
    case (ph)
      PH_OP:   idx = 3'd0;
      PH_UNIT: idx = 3'd3;
      PH_COL:  idx = 3'd3;
      default: idx = 3'd7;
    endcase
    return idx;
  endfunction

endpackage

/* hdl/log_record_deframer_crc32.sv */
// Log record deframer with CRC-32 check: top level.
// Depends on lrd_pkg (phase enum, result struct, CRC byte update).
//
//  channel | dir | signals                              | content
//  s_*     | in  | s_tvalid s_tready s_tdata s_tlast    | stream byte, tlast = stream end
//  m_*     | out | m_tvalid m_tready m_tdata m_tuser m_tlast | payload byte or header+status
//  apb     | in  | psel penable pwrite paddr pwdata prdata pready | 0x0 magic, 0x8 null length
//
// One byte per cycle while s_tready is high: the CRC byte update and the 64-bit
// payload count compare sit between the parser state and the result register.
// A two-entry output (register plus skid) keeps s_tready registered; input stalls
// only when both entries hold results. rst is synchronous, active high, and
// clears parser state, registers and output valids.
module log_record_deframer_crc32 (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic         s_tlast,   // stream_end
  output logic         m_tvalid,
  input  logic         m_tready,
  // [7:0] payload_byte, [71:8] sequence_number, [79:72] operation_code,
  // [111:80] unit_id, [143:112] column_id, [207:144] row_id,
  // [271:208] transaction_id, [335:272] commit_number, [399:336] value_length
  output logic [399:0] m_tdata,
  output logic [2:0]   m_tuser,   // [0] result_kind, [2:1] status
  output logic         m_tlast,   // last
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  // configuration
  logic [31:0] record_magic;
  logic [63:0] null_length_marker;

  // parser state
  lrd_pkg::phase_t phase, phase_next;
  logic [63:0] cnt, cnt_next;
  logic [31:0] crc_reg, crc_reg_next;
  logic [31:0] magic_shift, magic_shift_next;
  logic [63:0] seq_hold, seq_hold_next;
  logic [7:0]  op_hold, op_hold_next;
  logic [31:0] unit_hold, unit_hold_next;
  logic [31:0] column_hold, column_hold_next;
  logic [63:0] row_hold, row_hold_next;
  logic [63:0] txn_hold, txn_hold_next;
  logic [63:0] commit_hold, commit_hold_next;
  logic [63:0] length_hold, length_hold_next;
  logic [31:0] crc_field, crc_field_next;

  // output stage
  logic             out_valid, skid_valid;
  lrd_pkg::result_t out_res, skid_res, res;
  logic             emit;

  logic        accept;
  logic [7:0]  b;
  logic [63:0] cnt_inc;
  logic [31:0] crc_upd;
  logic [31:0] magic_word, stored_word;
  logic [63:0] len_word;
  logic        word_done, field_done, payload_done, magic_ok, crc_ok, len_empty;

  assign pready   = 1'b1;
  assign prdata   = (paddr[3] == lrd_pkg::REG_NULL_LEN) ? null_length_marker
                                                        : {32'd0, record_magic};
  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign b        = s_tdata;

  assign cnt_inc      = cnt + 64'd1;
  assign crc_upd      = lrd_pkg::crc_byte(crc_reg, b);
  assign magic_word   = magic_shift | ({24'd0, b} << {cnt[1:0], 3'b000});
  assign stored_word  = crc_field | ({24'd0, b} << {cnt[1:0], 3'b000});
  assign len_word     = length_hold | ({56'd0, b} << {cnt[2:0], 3'b000});
  assign word_done    = (cnt[1:0] == 2'd3);
  assign field_done   = (cnt[2:0] == lrd_pkg::field_last_idx(phase));
  assign payload_done = (cnt_inc == length_hold);
  assign magic_ok     = (magic_word == record_magic);
  assign crc_ok       = (stored_word == ~crc_reg);
  assign len_empty    = (len_word == 64'd0) || (len_word == null_length_marker);

  always_ff @(posedge clk) begin
    if (rst) begin
      record_magic       <= lrd_pkg::MAGIC_RESET;
      null_length_marker <= lrd_pkg::NULL_LEN_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[3] == lrd_pkg::REG_NULL_LEN) begin
        null_length_marker <= pwdata;
      end else begin
        record_magic <= pwdata[31:0];
      end
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      if (s_tlast) begin
        phase_next = lrd_pkg::PH_MAGIC;
      end else begin
        case (phase)
          lrd_pkg::PH_MAGIC: begin
            if (word_done) phase_next = magic_ok ? lrd_pkg::PH_SEQ : lrd_pkg::PH_DISCARD;
          end
          lrd_pkg::PH_SEQ:    if (field_done) phase_next = lrd_pkg::PH_OP;
          lrd_pkg::PH_OP:     if (field_done) phase_next = lrd_pkg::PH_UNIT;
          lrd_pkg::PH_UNIT:   if (field_done) phase_next = lrd_pkg::PH_COL;
          lrd_pkg::PH_COL:    if (field_done) phase_next = lrd_pkg::PH_ROW;
          lrd_pkg::PH_ROW:    if (field_done) phase_next = lrd_pkg::PH_TXN;
          lrd_pkg::PH_TXN:    if (field_done) phase_next = lrd_pkg::PH_COMMIT;
          lrd_pkg::PH_COMMIT: if (field_done) phase_next = lrd_pkg::PH_LEN;
          lrd_pkg::PH_LEN: begin
            if (field_done) phase_next = len_empty ? lrd_pkg::PH_CRC : lrd_pkg::PH_PAYLOAD;
          end
          lrd_pkg::PH_PAYLOAD: if (payload_done) phase_next = lrd_pkg::PH_CRC;
          lrd_pkg::PH_CRC: begin
            if (word_done) phase_next = crc_ok ? lrd_pkg::PH_MAGIC : lrd_pkg::PH_DISCARD;
          end
          default: phase_next = phase;
        endcase
      end
    end
  end

  // datapath registers
  always_comb begin
    cnt_next         = cnt;
    crc_reg_next     = crc_reg;
    magic_shift_next = magic_shift;
    seq_hold_next    = seq_hold;
    op_hold_next     = op_hold;
    unit_hold_next   = unit_hold;
    column_hold_next = column_hold;
    row_hold_next    = row_hold;
    txn_hold_next    = txn_hold;
    commit_hold_next = commit_hold;
    length_hold_next = length_hold;
    crc_field_next   = crc_field;
    if (accept) begin
      if (s_tlast || (phase == lrd_pkg::PH_CRC && word_done && crc_ok)) begin
        // re-arm
        cnt_next         = 64'd0;
        crc_reg_next     = lrd_pkg::CRC_INIT;
        magic_shift_next = 32'd0;
        seq_hold_next    = 64'd0;
        op_hold_next     = 8'd0;
        unit_hold_next   = 32'd0;
        column_hold_next = 32'd0;
        row_hold_next    = 64'd0;
        txn_hold_next    = 64'd0;
        commit_hold_next = 64'd0;
        length_hold_next = 64'd0;
        crc_field_next   = 32'd0;
      end else begin
        case (phase)
          lrd_pkg::PH_DISCARD: cnt_next = cnt;
          lrd_pkg::PH_MAGIC: begin
            crc_reg_next     = crc_upd;
            magic_shift_next = magic_word;
            cnt_next         = word_done ? 64'd0 : cnt_inc;
          end
          lrd_pkg::PH_PAYLOAD: begin
            crc_reg_next = crc_upd;
            cnt_next     = payload_done ? 64'd0 : cnt_inc;
          end
          lrd_pkg::PH_CRC: begin
            crc_field_next = stored_word;
            cnt_next       = word_done ? 64'd0 : cnt_inc;
          end
          default: begin
            crc_reg_next = crc_upd;
            cnt_next     = field_done ? 64'd0 : cnt_inc;
            case (phase)
              lrd_pkg::PH_SEQ:    seq_hold_next[{cnt[2:0], 3'b000} +: 8] = b;
              lrd_pkg::PH_OP:     op_hold_next = b;
              lrd_pkg::PH_UNIT:   unit_hold_next[{cnt[1:0], 3'b000} +: 8] = b;
              lrd_pkg::PH_COL:    column_hold_next[{cnt[1:0], 3'b000} +: 8] = b;
              lrd_pkg::PH_ROW:    row_hold_next[{cnt[2:0], 3'b000} +: 8] = b;
              lrd_pkg::PH_TXN:    txn_hold_next[{cnt[2:0], 3'b000} +: 8] = b;
              lrd_pkg::PH_COMMIT: commit_hold_next[{cnt[2:0], 3'b000} +: 8] = b;
              default:            length_hold_next = len_word;
            endcase
          end
        endcase
      end
    end
  end

  // result for the accepted byte
  always_comb begin
    emit        = 1'b0;
    res         = '0;
    res.kind    = lrd_pkg::KIND_HEADER;
    res.seq     = seq_hold;
    res.op      = op_hold;
    res.unit    = unit_hold;
    res.col     = column_hold;
    res.row     = row_hold;
    res.txn     = txn_hold;
    res.commit  = commit_hold;
    res.len     = length_hold;
    res.status  = lrd_pkg::ST_OK;
    res.last    = 1'b1;
    if (accept) begin
      if (s_tlast) begin
        // truncated only if some byte of a record has arrived
        emit = (phase != lrd_pkg::PH_DISCARD) &&
               !(phase == lrd_pkg::PH_MAGIC && cnt == 64'd0);
        res.status = lrd_pkg::ST_TRUNC;
      end else begin
        case (phase)
          lrd_pkg::PH_MAGIC: begin
            emit       = word_done && !magic_ok;
            res.status = lrd_pkg::ST_BAD_MAGIC;
          end
          lrd_pkg::PH_PAYLOAD: begin
            emit        = 1'b1;
            res         = '0;
            res.kind    = lrd_pkg::KIND_PAYLOAD;
            res.payload = b;
          end
          lrd_pkg::PH_CRC: begin
            emit       = word_done;
            res.status = crc_ok ? lrd_pkg::ST_OK : lrd_pkg::ST_CRC_ERR;
          end
          default: emit = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= lrd_pkg::PH_MAGIC;
      cnt         <= 64'd0;
      crc_reg     <= lrd_pkg::CRC_INIT;
      magic_shift <= 32'd0;
      seq_hold    <= 64'd0;
      op_hold     <= 8'd0;
      unit_hold   <= 32'd0;
      column_hold <= 32'd0;
      row_hold    <= 64'd0;
      txn_hold    <= 64'd0;
      commit_hold <= 64'd0;
      length_hold <= 64'd0;
      crc_field   <= 32'd0;
    end else begin
      phase       <= phase_next;
      cnt         <= cnt_next;
      crc_reg     <= crc_reg_next;
      magic_shift <= magic_shift_next;
      seq_hold    <= seq_hold_next;
      op_hold     <= op_hold_next;
      unit_hold   <= unit_hold_next;
      column_hold <= column_hold_next;
      row_hold    <= row_hold_next;
      txn_hold    <= txn_hold_next;
      commit_hold <= commit_hold_next;
      length_hold <= length_hold_next;
      crc_field   <= crc_field_next;
    end
  end

  // output register with skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= emit;
      end
    end else if (emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_res <= skid_valid ? skid_res : res;
    end else if (emit) begin
      skid_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.len, out_res.commit, out_res.txn, out_res.row, out_res.col,
                     out_res.unit, out_res.op, out_res.seq, out_res.payload};
  assign m_tuser  = {out_res.status, out_res.kind};
  assign m_tlast  = out_res.last;

endmodule

/* dv/log_record_deframer_crc32_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for log_record_deframer_crc32: builds little-endian log
// records (good, corrupted, truncated), predicts payload and header transactions.
// Depends on lrd_pkg for the result struct, phase enum and register/status codes.
module log_record_deframer_crc32_tb;

  localparam int LIMIT = 500000;
  localparam int HDR_BYTES = 53;

  class record_scoreboard;
    logic [31:0]      magic_cfg;
    logic [63:0]      null_len;
    lrd_pkg::phase_t  ph;
    logic [63:0]      cnt;
    logic [31:0]      crc;
    logic [31:0]      magic_acc;
    logic [31:0]      crc_acc;
    logic [63:0]      fld [16];
    lrd_pkg::result_t pending_results[$];
    int               errors;
    int               n_bytes;
    int               n_payload;
    int               n_status [4];

    function new();
      magic_cfg = lrd_pkg::MAGIC_RESET;
      null_len  = lrd_pkg::NULL_LEN_RESET;
      rearm();
    endfunction

    static function logic [31:0] crc_step8(logic [31:0] c_in, logic [7:0] b);
      logic [31:0] c;
      c = c_in ^ {24'd0, b};
      for (int k = 0; k < 8; k++) c = {1'b0, c[31:1]} ^ (c[0] ? lrd_pkg::CRC_POLY : 32'd0);
      return c;
    endfunction

    function void rearm();
      ph = lrd_pkg::PH_MAGIC;
      cnt = '0;
      crc = lrd_pkg::CRC_INIT;
      magic_acc = '0;
      crc_acc = '0;
      foreach (fld[i]) fld[i] = '0;
    endfunction

    function void queue_result(lrd_pkg::result_t r);
      pending_results.insert(pending_results.size(), r);
    endfunction

    function int field_bytes(lrd_pkg::phase_t p);
      case (p)
        lrd_pkg::PH_OP:                  return 1;
        lrd_pkg::PH_UNIT, lrd_pkg::PH_COL: return 4;
        default:                         return 8;
      endcase
    endfunction

    function lrd_pkg::result_t header(logic [1:0] st);
      lrd_pkg::result_t r;
      r = '0;
      r.kind   = lrd_pkg::KIND_HEADER;
      r.seq    = fld[lrd_pkg::PH_SEQ];
      r.op     = fld[lrd_pkg::PH_OP][7:0];
      r.unit   = fld[lrd_pkg::PH_UNIT][31:0];
      r.col    = fld[lrd_pkg::PH_COL][31:0];
      r.row    = fld[lrd_pkg::PH_ROW];
      r.txn    = fld[lrd_pkg::PH_TXN];
      r.commit = fld[lrd_pkg::PH_COMMIT];
      r.len    = fld[lrd_pkg::PH_LEN];
      r.status = st;
      r.last   = 1'b1;
      n_status[st]++;
      return r;
    endfunction

    // one accepted input transaction
    function void take_byte(logic [7:0] b, logic eos);
      lrd_pkg::result_t r;
      n_bytes++;
      if (eos) begin
        if (ph != lrd_pkg::PH_DISCARD && !(ph == lrd_pkg::PH_MAGIC && cnt == 0))
          queue_result(header(lrd_pkg::ST_TRUNC));
        rearm();
        return;
      end
      case (ph)
        lrd_pkg::PH_DISCARD: ;
        lrd_pkg::PH_MAGIC: begin
          crc = crc_step8(crc, b);
          magic_acc[8*cnt[1:0] +: 8] = b;
          cnt++;
          if (cnt == 64'd4) begin
            cnt = '0;
            if (magic_acc != magic_cfg) begin
              queue_result(header(lrd_pkg::ST_BAD_MAGIC));
              ph = lrd_pkg::PH_DISCARD;
            end else begin
              ph = lrd_pkg::PH_SEQ;
            end
          end
        end
        lrd_pkg::PH_PAYLOAD: begin
          crc = crc_step8(crc, b);
          r = '0;
          r.kind = lrd_pkg::KIND_PAYLOAD;
          r.payload = b;
          queue_result(r);
          cnt++;
          if (cnt == fld[lrd_pkg::PH_LEN]) begin
            cnt = '0;
            ph = lrd_pkg::PH_CRC;
          end
        end
        lrd_pkg::PH_CRC: begin
          crc_acc[8*cnt[1:0] +: 8] = b;
          cnt++;
          if (cnt == 64'd4) begin
            if (crc_acc == ~crc) begin
              queue_result(header(lrd_pkg::ST_OK));
              rearm();
            end else begin
              queue_result(header(lrd_pkg::ST_CRC_ERR));
              cnt = '0;
              ph = lrd_pkg::PH_DISCARD;
            end
          end
        end
        default: begin
          crc = crc_step8(crc, b);
          fld[ph][8*cnt[2:0] +: 8] = b;
          cnt++;
          if (cnt == 64'(field_bytes(ph))) begin
            cnt = '0;
            if (ph == lrd_pkg::PH_LEN)
              ph = (fld[lrd_pkg::PH_LEN] == 64'd0 || fld[lrd_pkg::PH_LEN] == null_len) ?
                   lrd_pkg::PH_CRC : lrd_pkg::PH_PAYLOAD;
            else
              ph = lrd_pkg::phase_t'(ph + 1);
          end
        end
      endcase
    endfunction

    function bit differs(string f, logic [63:0] e, logic [63:0] a);
      if (e === a) return 1'b0;
      if (errors < 10) $display("mismatch in %s: expected %h, got %h", f, e, a);
      return 1'b1;
    endfunction

    // one accepted output transaction
    function void check_result(lrd_pkg::result_t a);
      lrd_pkg::result_t e;
      bit bad;
      if (pending_results.size() == 0) begin
        if (errors < 10)
          $display("unexpected result: kind %0d status %0d payload %h", a.kind, a.status,
                   a.payload);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (e.kind == lrd_pkg::KIND_PAYLOAD) n_payload++;
      bad = 1'b0;
      bad |= differs("result_kind", 64'(e.kind), 64'(a.kind));
      bad |= differs("payload_byte", 64'(e.payload), 64'(a.payload));
      bad |= differs("sequence_number", e.seq, a.seq);
      bad |= differs("operation_code", 64'(e.op), 64'(a.op));
      bad |= differs("unit_id", 64'(e.unit), 64'(a.unit));
      bad |= differs("column_id", 64'(e.col), 64'(a.col));
      bad |= differs("row_id", e.row, a.row);
      bad |= differs("transaction_id", e.txn, a.txn);
      bad |= differs("commit_number", e.commit, a.commit);
      bad |= differs("value_length", e.len, a.len);
      bad |= differs("status", 64'(e.status), 64'(a.status));
      bad |= differs("last", 64'(e.last), 64'(a.last));
      if (bad) errors++;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic         clk;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata  = 8'd0;
  logic         s_tlast  = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [399:0] m_tdata;
  logic [2:0]   m_tuser;
  logic         m_tlast;
  logic         psel     = 1'b0;
  logic         penable  = 1'b0;
  logic         pwrite   = 1'b0;
  logic [3:0]   paddr    = 4'd0;
  logic [63:0]  pwdata   = 64'd0;
  logic [63:0]  prdata;
  logic         pready;

  log_record_deframer_crc32 uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  record_scoreboard sb;
  lrd_pkg::result_t got;
  logic [7:0] rec_q[$];   // bytes of the record being built
  logic [8:0] feed_q[$];  // {stream_end, byte} waiting to be sent
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  bit         hold_req = 1'b0;
  int         cycles = 0;

  assign got = '{kind: m_tuser[0], payload: m_tdata[7:0], seq: m_tdata[71:8],
                 op: m_tdata[79:72], unit: m_tdata[111:80], col: m_tdata[143:112],
                 row: m_tdata[207:144], txn: m_tdata[271:208], commit: m_tdata[335:272],
                 len: m_tdata[399:336], status: m_tuser[2:1], last: m_tlast};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.take_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_result(got);
    end
  end

  // receiver; a hold request blocks the output for a long stretch
  initial begin : rx_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic [63:0] pick64();
    case ($urandom_range(9))
      0:       return 64'd0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void put_le(logic [63:0] v, int n);
    for (int i = 0; i < n; i++) rec_q.insert(rec_q.size(), v[8*i +: 8]);
  endfunction

  function automatic void build_record(logic [31:0] mg, logic [63:0] sq, logic [7:0] op,
                                       logic [31:0] un, logic [31:0] cl, logic [63:0] rw,
                                       logic [63:0] tx, logic [63:0] cm, logic [63:0] ln,
                                       int npay, bit corrupt);
    logic [31:0] c;
    rec_q.delete();
    put_le(64'(mg), 4); put_le(sq, 8); put_le(64'(op), 1); put_le(64'(un), 4);
    put_le(64'(cl), 4); put_le(rw, 8); put_le(tx, 8); put_le(cm, 8); put_le(ln, 8);
    if (ln != 64'd0 && ln != sb.null_len)
      for (int i = 0; i < npay; i++) rec_q.insert(rec_q.size(), 8'($urandom));
    c = lrd_pkg::CRC_INIT;
    foreach (rec_q[i]) c = record_scoreboard::crc_step8(c, rec_q[i]);
    c = ~c;
    if (corrupt) c = c ^ (32'd1 << $urandom_range(31));
    put_le(64'(c), 4);
  endfunction

  function automatic void random_record(logic [31:0] mg, logic [63:0] ln, int npay,
                                        bit corrupt);
    build_record(mg, pick64(), 8'(pick64()), 32'(pick64()), 32'(pick64()), pick64(),
                 pick64(), pick64(), ln, npay, corrupt);
  endfunction

  // queue rec_q[lo .. hi-1]; hi < 0 means to the end
  function automatic void queue_rec(int lo, int hi);
    int top;
    top = (hi < 0 || hi > rec_q.size()) ? rec_q.size() : hi;
    for (int i = lo; i < top; i++) feed_q.insert(feed_q.size(), {1'b0, rec_q[i]});
  endfunction

  function automatic void queue_end();
    feed_q.insert(feed_q.size(), {1'b1, 8'($urandom)});
  endfunction

  function automatic void queue_noise(int n);
    repeat (n) feed_q.insert(feed_q.size(), {1'b0, 8'($urandom)});
  endfunction

  task automatic send_feed();
    logic [8:0] it;
    while (feed_q.size() > 0) begin
      it = feed_q.pop_front();
      while ($urandom_range(99) < tx_idle_pct) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= it[7:0];
      s_tlast  <= it[8];
      @(posedge clk);
      while (!s_tready) @(posedge clk);
    end
    s_tvalid <= 1'b0;
  endtask

  // register write once all results are in and the pipeline has settled
  task automatic write_reg(logic sel, logic [63:0] v);
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {sel, 3'b000};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == lrd_pkg::REG_MAGIC) sb.magic_cfg = v[31:0];
    else sb.null_len = v;
  endtask

  task automatic random_phase(int goal);
    int sel;
    int np;
    logic [63:0] ln;
    while (feed_q.size() < goal) begin
      sel = $urandom_range(99);
      np  = $urandom_range(8);
      ln  = 64'(np);
      if ($urandom_range(9) == 0) ln = sb.null_len;
      if (sel < 60) begin
        random_record(sb.magic_cfg, ln, np, 1'b0);
        queue_rec(0, -1);
      end else if (sel < 70) begin
        random_record(sb.magic_cfg, ln, np, 1'b1);
        queue_rec(0, -1);
        queue_noise($urandom_range(6));
        queue_end();
      end else if (sel < 80) begin
        if ($urandom_range(3) == 0) ln = {1'b1, 63'(pick64())};
        random_record(sb.magic_cfg, ln, np, 1'b0);
        queue_rec(0, $urandom_range(1, rec_q.size() - 1));
        queue_end();
      end else if (sel < 88) begin
        int k;
        random_record(sb.magic_cfg, ln, np, 1'b0);
        k = $urandom_range(3);
        rec_q[k] = rec_q[k] ^ (8'd1 << $urandom_range(7));
        queue_rec(0, -1);
        queue_end();
      end else if (sel < 95) begin
        queue_noise($urandom_range(1, 20));
        queue_end();
      end else begin
        queue_end();
      end
    end
    send_feed();
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, reset register values
    tx_idle_pct = 9;
    rx_idle_pct = 87;
    queue_end();                                           // stream end with nothing open
    build_record(32'd0, '0, '0, '0, '0, '0, '0, '0, 64'd0, 0, 1'b0);
    queue_rec(0, -1);
    build_record(32'd0, '1, '1, '1, '1, '1, '1, '1, 64'hFFFF_FFFF, 0, 1'b0);  // null length
    queue_rec(0, -1);
    random_record(32'd0, 64'd1, 1, 1'b0);
    queue_rec(0, -1);
    random_record(32'd0, '1, 5, 1'b0);                     // huge length, cut in payload
    queue_rec(0, HDR_BYTES + 5);
    queue_end();
    send_feed();

    write_reg(lrd_pkg::REG_MAGIC, 64'hC0DE_1234);
    random_record(sb.magic_cfg, 64'd2, 2, 1'b0);           // bad magic, rest discarded
    rec_q[0] = rec_q[0] ^ 8'h01;
    queue_rec(0, -1);
    queue_end();
    random_record(sb.magic_cfg, 64'd3, 3, 1'b1);           // stored CRC wrong
    queue_rec(0, -1);
    queue_noise(3);
    queue_end();
    random_record(sb.magic_cfg, 64'd0, 0, 1'b0);
    queue_rec(0, 1);                                       // end after one byte
    queue_end();
    queue_rec(0, 4);                                       // end right after the magic
    queue_end();
    queue_rec(0, 9);                                       // end inside sequence number
    queue_end();
    random_record(sb.magic_cfg, 64'd2, 2, 1'b0);
    queue_rec(0, rec_q.size() - 2);                        // end inside stored CRC
    queue_end();
    build_record(32'h5A5A_0F0F, pick64(), 8'h00, '1, '0, pick64(), pick64(), pick64(),
                 64'd4, 4, 1'b0);
    queue_rec(0, 2);
    send_feed();
    write_reg(lrd_pkg::REG_MAGIC, 64'h5A5A_0F0F);          // takes effect mid-record
    queue_rec(2, -1);
    send_feed();

    write_reg(lrd_pkg::REG_NULL_LEN, 64'd3);
    random_record(sb.magic_cfg, 64'd3, 3, 1'b0);           // length equals null marker
    queue_rec(0, -1);
    send_feed();

    // random part
    tx_idle_pct = 9;
    rx_idle_pct = 87;
    write_reg(lrd_pkg::REG_MAGIC, 64'($urandom));
    write_reg(lrd_pkg::REG_NULL_LEN, 64'd5);
    random_phase(200);

    tx_idle_pct = 87;
    rx_idle_pct = 9;
    write_reg(lrd_pkg::REG_MAGIC, 64'hFFFF_FFFF);
    write_reg(lrd_pkg::REG_NULL_LEN, '1);
    random_phase(200);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(lrd_pkg::REG_MAGIC, 64'd0);
    write_reg(lrd_pkg::REG_NULL_LEN, 64'd0);
    hold_req = 1'b1;
    random_phase(200);

    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d stream bytes; %0d payload bytes forwarded", sb.n_bytes, sb.n_payload);
    $display("Headers: %0d ok, %0d bad magic, %0d CRC error, %0d truncated; %0d mismatches",
             sb.n_status[lrd_pkg::ST_OK], sb.n_status[lrd_pkg::ST_BAD_MAGIC],
             sb.n_status[lrd_pkg::ST_CRC_ERR], sb.n_status[lrd_pkg::ST_TRUNC], sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

/* sim.f */
hdl/lrd_pkg.sv
hdl/log_record_deframer_crc32.sv
dv/log_record_deframer_crc32_tb.sv
